[design/jrd_pkg.sv]
// ----------------------------------------------------------------------------
// jrd_pkg
// shared types and constants of the radial deadzone block
// ----------------------------------------------------------------------------
package jrd_pkg;

  localparam int FRAC_BITS  = 15;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // register map
  localparam logic REG_STICK_DZ = 1'b0;
  localparam logic REG_TRIG_DZ  = 1'b1;

  // input mode codes
  localparam logic MODE_STICK = 1'b0;
  localparam logic MODE_TRIG  = 1'b1;

  // pipeline depth of the back end
  localparam int SQ_STEPS = 16;
  localparam int DV_STEPS = FRAC_BITS;
  localparam int SC_STEPS = 16;
  localparam int S_SET    = 1 + SQ_STEPS;
  localparam int S_MUL    = S_SET + 1 + DV_STEPS;
  localparam int N_STG    = S_MUL + 1 + SC_STEPS;

  // classified sample from the front end
  typedef struct packed {
    logic               mode;
    logic               negx;
    logic               negy;
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic [30:0]        xsq;
    logic [30:0]        ysq;
    logic               tok;
    logic [14:0]        tnum;
  } item_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_st_t;

endpackage

[design/joystick_radial_deadzone.sv]
// ----------------------------------------------------------------------------
// joystick_radial_deadzone
// radial stick deadzone and trigger threshold remap in q1.15
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+---------------------
//  samples   | push, full, mode_i, axis_*_i, trigger_*_i | push && !full
//  results   | empty, pop, out_x_o, out_y_o              | pop && !empty
//  config    | psel, penable, pwrite, paddr, pwdata      | psel&&penable&&pwrite
//
//  one sample per cycle sustained while results are popped; after the sample
//  transfer it passes the front register, queue, 50 back stages and output
//  slot before empty goes low; the stages hold the 16-step square root, the
//  15-step remap divide and the 16-step scaling divide, each one bit per pipeline stage
//  reset clears the deadzones to zero and empties every stage
//  a held result stalls the back pipe; the queue keeps the front taking samples until it fills
//
module joystick_radial_deadzone (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample side
  input  logic               push,
  output logic               full,
  input  logic               mode_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] trigger_level_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // deadzone registers, q0.15
  logic [14:0] dz_stick_q, dz_trig_q;
  logic        cfg_wr;

  jrd_pkg::item_t    fr_item, fifo_item;
  logic              fr_valid;
  jrd_pkg::fifo_st_t fifo_st;
  logic              bk_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // byte address 4*i selects register i
  assign prdata = (paddr[2] == jrd_pkg::REG_TRIG_DZ) ? {17'b0, dz_trig_q}
                                                     : {17'b0, dz_stick_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_stick_q <= '0;
      dz_trig_q  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == jrd_pkg::REG_STICK_DZ) begin
        dz_stick_q <= pwdata[14:0];
      end else begin
        dz_trig_q <= pwdata[14:0];
      end
    end
  end

  // front: squares and trigger classification
  jrd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .mode_i          (mode_i),
    .axis_x_i        (axis_x_i),
    .axis_y_i        (axis_y_i),
    .trigger_level_i (trigger_level_i),
    .dz_trig_i       (dz_trig_q),
    .fifo_full_i     (fifo_st.full),
    .item_valid_o    (fr_valid),
    .item_o          (fr_item)
  );

  // decoupling queue
  jrd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fr_valid),
    .data_i   (fr_item),
    .pop_i    (bk_ready),
    .data_o   (fifo_item),
    .status_o (fifo_st)
  );

  // back: root, divides, output slot
  jrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!fifo_st.empty),
    .item_i       (fifo_item),
    .item_ready_o (bk_ready),
    .dz_stick_i   (dz_stick_q),
    .dz_trig_i    (dz_trig_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o)
  );

  // queue never holds more than its depth
  a_fifo_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_st.count <= jrd_pkg::FIFO_CNT_W'(jrd_pkg::FIFO_DEPTH))
    else $error("queue count over depth");

  // full and empty queue flags are exclusive
  a_fifo_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_st.full && fifo_st.empty))
    else $error("queue both full and empty");

  // a stick deadzone write lands in the register
  a_cfg_stick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (paddr[2] == jrd_pkg::REG_STICK_DZ) |=> dz_stick_q == $past(pwdata[14:0]))
    else $error("stick deadzone write lost");

  // a trigger deadzone write lands in the register
  a_cfg_trig : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (paddr[2] == jrd_pkg::REG_TRIG_DZ) |=> dz_trig_q == $past(pwdata[14:0]))
    else $error("trigger deadzone write lost");

endmodule

[design/jrd_front.sv]
// ----------------------------------------------------------------------------
// jrd_front
// takes samples, squares the axes and classifies the trigger level
// ----------------------------------------------------------------------------
module jrd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 mode_i,
  input  logic signed [15:0]   axis_x_i,
  input  logic signed [15:0]   axis_y_i,
  input  logic signed [15:0]   trigger_level_i,
  input  logic [14:0]          dz_trig_i,
  input  logic                 fifo_full_i,
  output logic                 item_valid_o,
  output jrd_pkg::item_t       item_o
);

  logic           vld_q, vld_d;
  jrd_pkg::item_t item_q, item_d;
  logic           take;
  logic signed [31:0] xsq, ysq;

  assign full_o       = vld_q && fifo_full_i;
  assign take         = push_i && !full_o;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  assign xsq = axis_x_i * axis_x_i;
  assign ysq = axis_y_i * axis_y_i;

  always_comb begin
    item_d      = item_q;
    vld_d       = vld_q;
    if (vld_q && !fifo_full_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d        = 1'b1;
      item_d.mode  = mode_i;
      item_d.negx  = axis_x_i[15];
      item_d.negy  = axis_y_i[15];
      item_d.ax    = axis_x_i[15] ? 16'(-axis_x_i) : 16'(axis_x_i);
      item_d.ay    = axis_y_i[15] ? 16'(-axis_y_i) : 16'(axis_y_i);
      item_d.xsq   = xsq[30:0];
      item_d.ysq   = ysq[30:0];
      // negative levels never clear the deadzone
      item_d.tok   = !trigger_level_i[15] && (trigger_level_i[14:0] >= dz_trig_i);
      item_d.tnum  = trigger_level_i[14:0] - dz_trig_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

[design/jrd_fifo.sv]
// ----------------------------------------------------------------------------
// jrd_fifo
// short queue between front and back end
// ----------------------------------------------------------------------------
module jrd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jrd_pkg::item_t     data_i,
  input  logic               pop_i,
  output jrd_pkg::item_t     data_o,
  output jrd_pkg::fifo_st_t  status_o
);

  jrd_pkg::item_t                      mem_q [jrd_pkg::FIFO_DEPTH];
  logic [jrd_pkg::FIFO_PTR_W-1:0]      wptr_q, rptr_q;
  logic [jrd_pkg::FIFO_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                do_push, do_pop;

  assign status_o.full  = (cnt_q == jrd_pkg::FIFO_CNT_W'(jrd_pkg::FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign status_o.count = cnt_q;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign data_o         = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[design/jrd_back.sv]
// ----------------------------------------------------------------------------
// jrd_back
// square root, deadzone remap divide, axis scaling divide and output slot
// ----------------------------------------------------------------------------
module jrd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  jrd_pkg::item_t      item_i,
  output logic                item_ready_o,
  input  logic [14:0]         dz_stick_i,
  input  logic [14:0]         dz_trig_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic signed [15:0]  out_x_o,
  output logic signed [15:0]  out_y_o
);

  typedef struct packed {
    logic        vld;
    logic        mode;
    logic        negx;
    logic        negy;
    logic        tok;
    logic        zero;
    logic        sat;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [14:0] tnum;
    logic [31:0] sq;
    logic [17:0] srem;
    logic [15:0] root;
    logic [15:0] den;
    logic [15:0] drem;
    logic [14:0] q;
    logic [15:0] n;
    logic [30:0] px;
    logic [30:0] py;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] qx;
    logic [15:0] qy;
  } bk_t;

  localparam logic [15:0] ONE_Q = 16'(1 << jrd_pkg::FRAC_BITS);

  function automatic bk_t f_prep(jrd_pkg::item_t it, logic v);
    bk_t r;
    r      = '0;
    r.vld  = v;
    r.mode = it.mode;
    r.negx = it.negx;
    r.negy = it.negy;
    r.ax   = it.ax;
    r.ay   = it.ay;
    r.tok  = it.tok;
    r.tnum = it.tnum;
    r.sq   = {1'b0, it.xsq} + {1'b0, it.ysq};
    return r;
  endfunction

  // one result bit of the digit-by-digit square root
  function automatic bk_t f_sqrt(bk_t a);
    bk_t         r;
    logic [17:0] sh;
    logic [17:0] trial;
    r     = a;
    sh    = {a.srem[15:0], a.sq[31:30]};
    trial = {a.root, 2'b01};
    if (sh >= trial) begin
      r.srem = sh - trial;
      r.root = {a.root[14:0], 1'b1};
    end else begin
      r.srem = sh;
      r.root = {a.root[14:0], 1'b0};
    end
    r.sq = {a.sq[29:0], 2'b00};
    return r;
  endfunction

  function automatic bk_t f_setup(bk_t a, logic [14:0] ds, logic [14:0] dt);
    bk_t         r;
    logic [15:0] num;
    r = a;
    if (a.mode == jrd_pkg::MODE_STICK) begin
      num    = a.root - {1'b0, ds};
      r.den  = ONE_Q - {1'b0, ds};
      r.zero = (a.root == '0) || (a.root < {1'b0, ds});
      r.sat  = (num >= r.den);
    end else begin
      num    = {1'b0, a.tnum};
      r.den  = ONE_Q - {1'b0, dt};
      r.zero = !a.tok;
      r.sat  = 1'b0;
    end
    r.drem = num;
    r.q    = '0;
    return r;
  endfunction

  // one quotient bit of (m - d) / (one - d), with the trigger level in place of m for triggers
  function automatic bk_t f_div(bk_t a);
    bk_t         r;
    logic [16:0] sh;
    r  = a;
    sh = {a.drem, 1'b0};
    if (sh >= {1'b0, a.den}) begin
      r.drem = 16'(sh - {1'b0, a.den});
      r.q    = {a.q[13:0], 1'b1};
    end else begin
      r.drem = sh[15:0];
      r.q    = {a.q[13:0], 1'b0};
    end
    return r;
  endfunction

  function automatic bk_t f_mul(bk_t a);
    bk_t         r;
    logic [31:0] prx;
    logic [31:0] pry;
    r    = a;
    r.n  = a.sat ? ONE_Q : {1'b0, a.q};
    prx  = a.ax * r.n;
    pry  = a.ay * r.n;
    // quotient fits 16 bits, so the top bits already sit below m
    r.rx = {1'b0, prx[30:16]};
    r.ry = {1'b0, pry[30:16]};
    r.px = {prx[15:0], 15'b0};
    r.py = {pry[15:0], 15'b0};
    r.qx = '0;
    r.qy = '0;
    return r;
  endfunction

  // one quotient bit of both axis products over m
  function automatic bk_t f_scale(bk_t a);
    bk_t         r;
    logic [16:0] shx;
    logic [16:0] shy;
    r   = a;
    shx = {a.rx, a.px[30]};
    shy = {a.ry, a.py[30]};
    if (shx >= {1'b0, a.root}) begin
      r.rx = 16'(shx - {1'b0, a.root});
      r.qx = {a.qx[14:0], 1'b1};
    end else begin
      r.rx = shx[15:0];
      r.qx = {a.qx[14:0], 1'b0};
    end
    if (shy >= {1'b0, a.root}) begin
      r.ry = 16'(shy - {1'b0, a.root});
      r.qy = {a.qy[14:0], 1'b1};
    end else begin
      r.ry = shy[15:0];
      r.qy = {a.qy[14:0], 1'b0};
    end
    r.px = {a.px[29:0], 1'b0};
    r.py = {a.py[29:0], 1'b0};
    return r;
  endfunction

  function automatic logic [15:0] f_sat(logic [15:0] mag, logic neg, logic zero);
    logic [15:0] r;
    if (zero) begin
      r = '0;
    end else if (neg) begin
      r = 16'(-mag);
    end else if (mag[15]) begin
      r = 16'h7fff;
    end else begin
      r = mag;
    end
    return r;
  endfunction

  bk_t         pipe_q [jrd_pkg::N_STG];
  bk_t         nxt    [jrd_pkg::N_STG];
  logic        en;
  logic        out_v_q;
  logic [15:0] ox_q, oy_q;
  logic [15:0] mag_x;
  bk_t         last;

  // whole pipe advances whenever the output slot frees up
  assign en           = !out_v_q || pop_i;
  assign item_ready_o = en;
  assign empty_o      = !out_v_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign last         = pipe_q[jrd_pkg::N_STG-1];

  for (genvar s = 0; s < jrd_pkg::N_STG; s++) begin : g_stg
    if (s == 0) begin : g_prep
      assign nxt[s] = f_prep(item_i, item_valid_i);
    end else if (s < jrd_pkg::S_SET) begin : g_sqrt
      assign nxt[s] = f_sqrt(pipe_q[s-1]);
    end else if (s == jrd_pkg::S_SET) begin : g_set
      assign nxt[s] = f_setup(pipe_q[s-1], dz_stick_i, dz_trig_i);
    end else if (s < jrd_pkg::S_MUL) begin : g_div
      assign nxt[s] = f_div(pipe_q[s-1]);
    end else if (s == jrd_pkg::S_MUL) begin : g_mul
      assign nxt[s] = f_mul(pipe_q[s-1]);
    end else begin : g_scale
      assign nxt[s] = f_scale(pipe_q[s-1]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[s] <= '0;
      end else if (en) begin
        pipe_q[s] <= nxt[s];
      end
    end
  end

  assign mag_x = (last.mode == jrd_pkg::MODE_TRIG) ? last.n : last.qx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
    end else if (en) begin
      out_v_q <= last.vld;
      ox_q    <= f_sat(mag_x, last.negx && (last.mode == jrd_pkg::MODE_STICK), last.zero);
      oy_q    <= f_sat(last.qy, last.negy,
                       last.zero || (last.mode == jrd_pkg::MODE_TRIG));
    end
  end

endmodule

[tb/joystick_radial_deadzone_test.sv]
// ----------------------------------------------------------------------------
// joystick_radial_deadzone_test
// self-checking bench for the radial stick and trigger deadzone remap
// ----------------------------------------------------------------------------
//
// samples are pushed in random bursts, results popped on a random stall
// pattern; a scoreboard class predicts each result from the sample and the
// deadzone settings and compares it field by field with what comes out
//
module joystick_radial_deadzone_test;

  // result pair of one sample
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } remap_t;

  class remap_board;
    remap_t           pending[$];
    logic [14:0]      stick_dz;
    logic [14:0]      trig_dz;
    int               errors;
    int               checked;

    function new();
      stick_dz = '0;
      trig_dz  = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    // bitwise integer square root, truncated
    function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned stretch(longint unsigned v, longint unsigned d);
      longint unsigned n;
      n = ((v - d) << jrd_pkg::FRAC_BITS) / ((64'd1 << jrd_pkg::FRAC_BITS) - d);
      if (n > (64'd1 << jrd_pkg::FRAC_BITS)) n = 64'd1 << jrd_pkg::FRAC_BITS;
      return n;
    endfunction

    function logic signed [15:0] clip(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function longint scale(longint a, longint unsigned n, longint unsigned m);
      longint unsigned mag;
      longint q;
      mag = (a < 0) ? -a : a;
      q = (mag * n) / m;
      return (a < 0) ? -q : q;
    endfunction

    // note an accepted sample and queue its expected result
    function void note_sample(logic md, logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] tl);
      longint          x, y, v, ox, oy;
      longint unsigned d, m;
      remap_t          r;
      ox = 0;
      oy = 0;
      if (md == jrd_pkg::MODE_STICK) begin
        x = ax;
        y = ay;
        d = stick_dz;
        m = root(x * x + y * y);
        if (m != 0 && m >= d) begin
          ox = scale(x, stretch(m, d), m);
          oy = scale(y, stretch(m, d), m);
        end
      end else begin
        v = tl;
        d = trig_dz;
        if (v >= 0 && v >= d) ox = stretch(v, d);
      end
      r.x = clip(ox);
      r.y = clip(oy);
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic signed [15:0] gx, logic signed [15:0] gy);
      remap_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, gx, gy);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (gx !== e.x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.x, gx);
        errors++;
      end
      if (gy !== e.y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.y, gy);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               mode_i = 1'b0;
  logic signed [15:0] axis_x_i = '0;
  logic signed [15:0] axis_y_i = '0;
  logic signed [15:0] trigger_level_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] out_x_o;
  logic signed [15:0] out_y_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  remap_board board = new();
  int         idle_cycles = 0;
  bit         hold_off = 1'b0;
  int         n_pushed = 0;

  localparam int LATENCY  = 60;
  localparam int WATCHDOG = 20000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  joystick_radial_deadzone u_top (.*);

  // result side: sample on the edge, note every accepted transfer
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) board.check_result(out_x_o, out_y_o);
  end

  // receiver stall pattern, with stretches of no stalls and one long hold-off
  initial begin
    int phase;
    @(posedge rst_ni);
    forever begin
      phase = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(posedge clk_i);
        if (hold_off) pop <= 1'b0;
        else if (phase == 0) pop <= 1'b1;
        else pop <= ($urandom_range(0, 3) >= phase - 1);
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("joystick_radial_deadzone test failed");
      $finish;
    end
  end

  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == jrd_pkg::REG_STICK_DZ) board.stick_dz = val[14:0];
    else board.trig_dz = val[14:0];
  endtask

  // offer one sample and hold it until the transfer
  task automatic send(logic md, logic signed [15:0] ax, logic signed [15:0] ay,
                      logic signed [15:0] tl);
    push            <= 1'b1;
    mode_i          <= md;
    axis_x_i        <= ax;
    axis_y_i        <= ay;
    trigger_level_i <= tl;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_sample(md, ax, ay, tl);
    n_pushed++;
  endtask

  task automatic pause_sender();
    push <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // random sample; about one in four puts both axes within 1000 of the origin
  task automatic send_random();
    logic signed [15:0] ax, ay, tl;
    ax = 16'($urandom);
    ay = 16'($urandom);
    tl = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      ax = 16'(int'($urandom_range(0, 2000)) - 1000);
      ay = 16'(int'($urandom_range(0, 2000)) - 1000);
    end
    send(1'($urandom_range(0, 1)), ax, ay, tl);
  endtask

  initial begin
    logic [14:0] dz_set[5];
    int          burst;
    dz_set = '{15'd0, 15'd32767, 15'd8000, 15'd1, 15'd16384};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero deadzone extremes, origin, full corners, trigger edges
    send(jrd_pkg::MODE_STICK, 16'sd0, 16'sd0, 16'sd0);
    send(jrd_pkg::MODE_STICK, -16'sd32768, -16'sd32768, 16'sd0);
    send(jrd_pkg::MODE_STICK, 16'sd32767, 16'sd32767, -16'sd1);
    send(jrd_pkg::MODE_STICK, -16'sd32768, 16'sd0, 16'sd0);
    send(jrd_pkg::MODE_STICK, 16'sd0, 16'sd32767, 16'sd0);
    send(jrd_pkg::MODE_STICK, 16'sd1, -16'sd1, 16'sd0);
    send(jrd_pkg::MODE_TRIG, 16'sd0, 16'sd0, 16'sd0);
    send(jrd_pkg::MODE_TRIG, 16'sd5, 16'sd7, 16'sd32767);
    send(jrd_pkg::MODE_TRIG, 16'sd0, 16'sd0, -16'sd32768);
    send(jrd_pkg::MODE_TRIG, 16'sd0, 16'sd0, -16'sd1);
    drain();
    // directed: large deadzones, right at and just under the threshold
    reg_write(jrd_pkg::REG_STICK_DZ, 32'h7fff);
    reg_write(jrd_pkg::REG_TRIG_DZ, 32'hffff_7fff);
    send(jrd_pkg::MODE_STICK, 16'sd32767, 16'sd0, 16'sd0);
    send(jrd_pkg::MODE_STICK, 16'sd32766, 16'sd0, 16'sd0);
    send(jrd_pkg::MODE_STICK, -16'sd32768, -16'sd32768, 16'sd0);
    send(jrd_pkg::MODE_TRIG, 16'sd0, 16'sd0, 16'sd32767);
    send(jrd_pkg::MODE_TRIG, 16'sd0, 16'sd0, 16'sd32766);
    drain();
    reg_write(jrd_pkg::REG_STICK_DZ, 32'd100);
    reg_write(jrd_pkg::REG_TRIG_DZ, 32'd100);
    send(jrd_pkg::MODE_STICK, 16'sd60, 16'sd80, 16'sd0);
    send(jrd_pkg::MODE_STICK, 16'sd60, 16'sd79, 16'sd0);
    send(jrd_pkg::MODE_TRIG, 16'sd0, 16'sd0, 16'sd100);
    send(jrd_pkg::MODE_TRIG, 16'sd0, 16'sd0, 16'sd99);
    send(jrd_pkg::MODE_TRIG, 16'sd0, 16'sd0, 16'sd101);
    drain();

    // pressure: receiver held off while the sender keeps offering,
    // more samples than the pipe, queue and output slot can hold
    hold_off = 1'b1;
    fork
      repeat (150) @(posedge clk_i);
      repeat (100) send_random();
    join_any
    hold_off = 1'b0;
    wait fork;
    drain();

    // random phases over several deadzone settings
    for (int p = 0; p < 6; p++) begin
      reg_write(jrd_pkg::REG_STICK_DZ, p < 5 ? dz_set[p] : $urandom);
      reg_write(jrd_pkg::REG_TRIG_DZ, p < 5 ? dz_set[4 - p] : $urandom);
      for (int k = 0; k < 120; k += burst) begin
        burst = $urandom_range(1, 30);
        repeat (burst) send_random();
        if ($urandom_range(0, 2) != 0) pause_sender();
      end
      drain();
    end

    $display("covered %0d samples, %0d results checked, stick and trigger modes",
             n_pushed, board.checked);
    $display("deadzones swept from zero to full scale, with back-pressure stalls");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("joystick_radial_deadzone test passed");
    end else begin
      $display("joystick_radial_deadzone test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/jrd_pkg.sv
design/jrd_front.sv
design/jrd_fifo.sv
design/jrd_back.sv
design/joystick_radial_deadzone.sv
tb/joystick_radial_deadzone_test.sv
